// ===== src/cctk_pkg.sv =====
// ----------------------------------------------------------------------------
// cctk_pkg: shared types and helpers for the character class tokenizer
// Byte class tests, scan modes, token kinds and the record that travels
// from the classifier to the result stage.
// ----------------------------------------------------------------------------
package cctk_pkg;

  // Field widths fixed by the result format
  localparam int unsigned FIELD_BITS = 16;
  localparam int unsigned KIND_BITS  = 3;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Token kinds as reported on the result port
  typedef enum logic [KIND_BITS-1:0] {
    KIND_IDENT   = 3'd0,
    KIND_KEYWORD = 3'd1,
    KIND_WORD    = 3'd2,
    KIND_LITERAL = 3'd3,
    KIND_SEP     = 3'd4,
    KIND_TERM    = 3'd5,
    KIND_ERROR   = 3'd6
  } kind_t;

  // Scan modes; an open token's mode code equals its kind code
  typedef enum logic [KIND_BITS-1:0] {
    MODE_IDENT   = 3'd0,
    MODE_KEYWORD = 3'd1,
    MODE_WORD    = 3'd2,
    MODE_LITERAL = 3'd3,
    MODE_SEP     = 3'd4,
    MODE_IDLE    = 3'd7
  } mode_t;

  typedef struct packed {
    kind_t                 kind;
    logic [FIELD_BITS-1:0] start;
    logic [FIELD_BITS-1:0] len;
  } token_t;

  // Results caused by one byte: tok0 always, tok1 when two is set
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } entry_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_textc(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_UNDER;
  endfunction

  function automatic logic is_sepc(input logic [7:0] c);
    return c == CH_SQUOTE || c == CH_DQUOTE || c == CH_COMMA || c == CH_SEMI ||
           c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACK ||
           c == CH_RBRACK || c == CH_LBRACE || c == CH_RBRACE;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL;
  endfunction

  // True when byte c extends a token open in mode m
  function automatic logic continues(input mode_t m, input logic [7:0] c);
    logic r;
    unique case (m)
      MODE_IDENT, MODE_KEYWORD, MODE_WORD: r = is_textc(c);
      MODE_LITERAL:                        r = is_digit(c) || c == CH_DOT;
      MODE_SEP:                            r = is_sepc(c);
      default:                             r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/cctk_front.sv =====
// ----------------------------------------------------------------------------
// cctk_front: byte classifier and scan state
// Takes one byte per transfer, tracks the open token and position, and
// builds the record of the zero, one or two tokens that the byte closes.
// ----------------------------------------------------------------------------
module cctk_front #(
  parameter int unsigned POS_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  logic [7:0]       in_char_byte,
  input  logic             q_full,
  output logic             q_push,
  output cctk_pkg::entry_t q_data
);

  localparam int unsigned FB = cctk_pkg::FIELD_BITS;

  cctk_pkg::mode_t     mode_r, mode_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] ostart_r, ostart_nxt;

  logic                accept;
  logic [POS_BITS-1:0] pos_inc;
  logic [POS_BITS-1:0] len_raw;
  logic [FB-1:0]       pos_clip, ostart_clip, len_clip;

  assign accept = in_push && !q_full;

  // Saturating position increment
  assign pos_inc = (pos_r == {POS_BITS{1'b1}}) ? pos_r : pos_r + 1'b1;
  assign len_raw = (pos_r >= ostart_r) ? pos_r - ostart_r : '0;

  // Clip counters to the result field width
  generate
    if (POS_BITS > FB) begin : g_clip
      assign pos_clip    = (|pos_r[POS_BITS-1:FB])    ? '1 : pos_r[FB-1:0];
      assign ostart_clip = (|ostart_r[POS_BITS-1:FB]) ? '1 : ostart_r[FB-1:0];
      assign len_clip    = (|len_raw[POS_BITS-1:FB])  ? '1 : len_raw[FB-1:0];
    end else begin : g_ext
      assign pos_clip    = FB'(pos_r);
      assign ostart_clip = FB'(ostart_r);
      assign len_clip    = FB'(len_raw);
    end
  endgenerate

  // Classify the byte and decide the next state and the emitted tokens
  always_comb begin
    cctk_pkg::token_t close_tok;
    cctk_pkg::token_t tail_tok;
    logic             has_close;
    logic             has_tail;

    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    ostart_nxt = ostart_r;
    has_close  = 1'b0;
    has_tail   = 1'b0;

    close_tok.kind  = cctk_pkg::kind_t'(mode_r);
    close_tok.start = ostart_clip;
    close_tok.len   = len_clip;
    tail_tok.kind   = cctk_pkg::KIND_ERROR;
    tail_tok.start  = pos_clip;
    tail_tok.len    = FB'(1);

    if (mode_r != cctk_pkg::MODE_IDLE && cctk_pkg::continues(mode_r, in_char_byte)) begin
      pos_nxt = pos_inc;
    end else begin
      has_close = (mode_r != cctk_pkg::MODE_IDLE);
      mode_nxt  = cctk_pkg::MODE_IDLE;
      priority if (cctk_pkg::is_space(in_char_byte)) begin
        pos_nxt = pos_inc;
      end else if (in_char_byte == cctk_pkg::CH_AT || in_char_byte == cctk_pkg::CH_DOLLAR) begin
        mode_nxt   = cctk_pkg::MODE_IDENT;
        ostart_nxt = pos_r;
        pos_nxt    = pos_inc;
      end else if (in_char_byte == cctk_pkg::CH_DOT) begin
        mode_nxt   = cctk_pkg::MODE_KEYWORD;
        ostart_nxt = pos_r;
        pos_nxt    = pos_inc;
      end else if (cctk_pkg::is_alpha(in_char_byte)) begin
        mode_nxt   = cctk_pkg::MODE_WORD;
        ostart_nxt = pos_r;
        pos_nxt    = pos_inc;
      end else if (cctk_pkg::is_digit(in_char_byte)) begin
        mode_nxt   = cctk_pkg::MODE_LITERAL;
        ostart_nxt = pos_r;
        pos_nxt    = pos_inc;
      end else if (cctk_pkg::is_sepc(in_char_byte)) begin
        mode_nxt   = cctk_pkg::MODE_SEP;
        ostart_nxt = pos_r;
        pos_nxt    = pos_inc;
      end else if (in_char_byte == cctk_pkg::CH_NUL) begin
        // End of string: terminator, then rewind
        has_tail      = 1'b1;
        tail_tok.kind = cctk_pkg::KIND_TERM;
        tail_tok.len  = '0;
        pos_nxt       = '0;
        ostart_nxt    = '0;
      end else begin
        // Unknown byte: one-byte error token, consumed
        has_tail = 1'b1;
        pos_nxt  = pos_inc;
      end
    end

    q_push       = accept && (has_close || has_tail);
    q_data.two   = has_close && has_tail;
    q_data.tok0  = has_close ? close_tok : tail_tok;
    q_data.tok1  = tail_tok;
  end

  // Scan state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= cctk_pkg::MODE_IDLE;
      pos_r    <= '0;
      ostart_r <= '0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      ostart_r <= ostart_nxt;
    end
  end

endmodule

// ===== src/cctk_queue.sv =====
// ----------------------------------------------------------------------------
// cctk_queue: token record queue
// Short first-in first-out buffer that decouples the classifier from the
// result stage; the head record is presented without a read cycle.
// ----------------------------------------------------------------------------
module cctk_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  cctk_pkg::entry_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             rd_valid,
  output cctk_pkg::entry_t rd_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cctk_pkg::entry_t mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full     = (count_r == CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_wr, do_rd})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store records
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count above depth");

endmodule

// ===== src/cctk_back.sv =====
// ----------------------------------------------------------------------------
// cctk_back: result stage
// Holds one token record in an output register and hands out its one or
// two tokens in order, marking the last token caused by each byte.
// ----------------------------------------------------------------------------
module cctk_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  cctk_pkg::entry_t q_data,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output logic [2:0]       out_tok_kind,
  output logic [15:0]      out_tok_start,
  output logic [15:0]      out_tok_len,
  output logic             out_run_last
);

  cctk_pkg::entry_t hold_r, hold_nxt;
  logic             valid_r, valid_nxt;
  logic             idx_r, idx_nxt;
  logic             last_now;
  logic             taken;
  cctk_pkg::token_t cur;

  assign last_now = idx_r || !hold_r.two;
  assign taken    = pop && valid_r;
  assign q_pop    = q_valid && (!valid_r || (taken && last_now));
  assign cur      = idx_r ? hold_r.tok1 : hold_r.tok0;

  assign empty         = !valid_r;
  assign out_tok_kind  = cur.kind;
  assign out_tok_start = cur.start;
  assign out_tok_len   = cur.len;
  assign out_run_last  = last_now;

  // Step through the held record, reload from the queue when done
  always_comb begin
    hold_nxt  = hold_r;
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (taken) begin
      if (!last_now) begin
        idx_nxt = 1'b1;
      end else begin
        valid_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      hold_nxt  = q_data;
      idx_nxt   = 1'b0;
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

  a_second_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && idx_r) |-> hold_r.two)
    else $error("second token shown for a single-token record");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (taken && !last_now) |=> (valid_r && idx_r))
    else $error("second token of a pair lost");

  a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (cur.kind == cctk_pkg::KIND_TERM || cur.kind == cctk_pkg::KIND_ERROR))
      |-> last_now)
    else $error("terminator or error token not marked last");

endmodule

// ===== src/character_class_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// character_class_tokenizer_top: streaming character class tokenizer
// Cuts a byte stream into identifier, keyword, word, literal, separator,
// terminator and error tokens with start offset and length.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle while full is low; the classifier
// updates its scan state in that cycle and writes the byte's tokens, if any,
// as one record into a QUEUE_DEPTH-entry queue. The result stage hands out
// one token per cycle, while pop is high, from an output register, so a byte
// that both closes a token and yields a terminator or error yields two tokens
// on the result side; sustained input rate is one byte per cycle whenever
// results are drained at least as fast as they are produced. With the queue
// and result stage idle, a token passes through the queue and then the output
// register before it appears on the result ports. run_last marks the last
// token caused by a byte. Positions count in POS_BITS bits and saturate;
// reported starts and lengths saturate at 65535.
// ----------------------------------------------------------------------------
module character_class_tokenizer_top #(
  parameter int unsigned POS_BITS    = 16,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_char_byte,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_tok_kind,
  output logic [15:0] out_tok_start,
  output logic [15:0] out_tok_len,
  output logic        out_run_last
);

  logic             q_push, q_full, q_valid, q_pop;
  cctk_pkg::entry_t q_wdata, q_rdata;

  assign full = q_full;

  // Classify bytes and track scan state
  cctk_front #(
    .POS_BITS(POS_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (push),
    .in_char_byte(in_char_byte),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  // Decouple classifier from result stage
  cctk_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_valid(q_valid),
    .rd_data (q_rdata)
  );

  // Serialize tokens onto the result port
  cctk_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .out_tok_kind (out_tok_kind),
    .out_tok_start(out_tok_start),
    .out_tok_len  (out_tok_len),
    .out_run_last (out_run_last)
  );

endmodule
